/* rtl/core/ss3x3_pkg.sv */
package ss3x3_pkg;

  // Image and sample geometry.
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned SizeW     = 11;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned WeightW   = 16;

  // Arithmetic widths: a four-sample sum, a weighted term and the accumulator.
  localparam int unsigned SumW      = SampleW + 2;
  localparam int unsigned ProdW     = WeightW + SumW + 1;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned FracBits  = 15;

  // Configuration port.
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_SIZE    = 2'd0,
    CFG_WEIGHT_CORNER = 2'd1,
    CFG_WEIGHT_EDGE   = 2'd2,
    CFG_WEIGHT_CENTER = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [SizeW-1:0]   ResetImageSize    = 11'd1024;
  localparam logic [WeightW-1:0] ResetWeightCorner = 16'd1638;
  localparam logic [WeightW-1:0] ResetWeightEdge   = 16'd3277;
  localparam logic [WeightW-1:0] ResetWeightCenter = 16'd13107;

  localparam logic [AccW-1:0] RoundHalf = AccW'(1) << (FracBits - 1);

  // Side length in effect: sizes below three act as three, above the line
  // store depth act as the depth.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] res;
    if (size < SizeW'(3)) begin
      res = SizeW'(3);
    end else if (size > SizeW'(MaxWidth)) begin
      res = SizeW'(MaxWidth);
    end else begin
      res = size;
    end
    return res;
  endfunction

endpackage

/* rtl/core/ss3x3_ram.sv */
module ss3x3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; a read of the entry being
  // written in the same cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/stencil_smooth_3x3_core.sv */
// A result is registered in each pipeline stage and then in the output register before it is shown.
// Throughput: one sample per cycle; the line store read and write-back pipeline is full rate.
// The pipeline stalls only while the output register holds a result that is not taken.
// Reset clears the row and column counters, the six-entry window and all valid flags, and loads
// the register defaults. The line stores are not cleared; they are filled by the first rows.
module stencil_smooth_3x3_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ss3x3_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ss3x3_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample stream in.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ss3x3_pkg::SampleW-1:0]    s_axis_tdata,   // [15:0] sample
  input  logic                             s_axis_tuser,   // [0] frame_start
  // Filtered stream out.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ss3x3_pkg::SampleW-1:0]    m_axis_tdata,   // [15:0] smoothed
  output logic                             m_axis_tlast    // last_of_frame
);

  localparam int unsigned AddrW   = ss3x3_pkg::AddrW;
  localparam int unsigned SizeW   = ss3x3_pkg::SizeW;
  localparam int unsigned SampleW = ss3x3_pkg::SampleW;
  localparam int unsigned WeightW = ss3x3_pkg::WeightW;
  localparam int unsigned SumW    = ss3x3_pkg::SumW;
  localparam int unsigned ProdW   = ss3x3_pkg::ProdW;
  localparam int unsigned AccW    = ss3x3_pkg::AccW;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [SizeW-1:0]   image_size_q;
  logic [WeightW-1:0] w_corner_q, w_edge_q, w_center_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= ss3x3_pkg::ResetImageSize;
      w_corner_q   <= ss3x3_pkg::ResetWeightCorner;
      w_edge_q     <= ss3x3_pkg::ResetWeightEdge;
      w_center_q   <= ss3x3_pkg::ResetWeightCenter;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ss3x3_pkg::CFG_IMAGE_SIZE:    image_size_q <= cfg_data_i[SizeW-1:0];
        ss3x3_pkg::CFG_WEIGHT_CORNER: w_corner_q   <= cfg_data_i;
        ss3x3_pkg::CFG_WEIGHT_EDGE:   w_edge_q     <= cfg_data_i;
        ss3x3_pkg::CFG_WEIGHT_CENTER: w_center_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves unless a result waits in the output.
  logic out_valid_q;
  logic advance;
  logic in_accept;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && advance;

  // ---------------------------------------------------------------------------
  // Stage 0: position of the incoming sample and line store read.
  logic [AddrW-1:0] col_q, row_q, col_d, row_d;
  logic [AddrW-1:0] col_base, row_base, col0, row0, last_pos;
  logic [SizeW-1:0] size_eff, col0_p1, row0_p1;
  logic             produce0, last0;

  always_comb begin
    size_eff = ss3x3_pkg::eff_size(image_size_q);
    last_pos = AddrW'(size_eff - SizeW'(1));
    col_base = s_axis_tuser ? '0 : col_q;
    row_base = s_axis_tuser ? '0 : row_q;
    // Keep the position inside the image after a size change.
    col0 = ({1'b0, col_base} >= size_eff) ? last_pos : col_base;
    row0 = ({1'b0, row_base} >= size_eff) ? last_pos : row_base;
    col0_p1 = {1'b0, col0} + SizeW'(1);
    row0_p1 = {1'b0, row0} + SizeW'(1);
    produce0 = (row0 >= AddrW'(2)) && (col0 >= AddrW'(2));
    last0    = (row0 == last_pos) && (col0 == last_pos);
    if (col0_p1 >= size_eff) begin
      col_d = '0;
      row_d = (row0_p1 >= size_eff) ? '0 : row0_p1[AddrW-1:0];
    end else begin
      col_d = col0_p1[AddrW-1:0];
      row_d = row0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: a holds the previous row, b the row before that.
  logic               s1_valid_q;
  logic [AddrW-1:0]   s1_col_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_produce_q, s1_last_q, s1_fwd_q;
  logic [SampleW-1:0] fwd_mid_q, fwd_sample_q;
  logic [SampleW-1:0] rd_a, rd_b, top1, mid1;
  logic               wr_en;

  assign wr_en = advance && s1_valid_q;

  ss3x3_ram #(
    .Width (SampleW),
    .Depth (ss3x3_pkg::MaxWidth)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_accept),
    .raddr_i (col0),
    .rdata_o (rd_a)
  );

  ss3x3_ram #(
    .Width (SampleW),
    .Depth (ss3x3_pkg::MaxWidth)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (mid1),
    .re_i    (in_accept),
    .raddr_i (col0),
    .rdata_o (rd_b)
  );

  // Stage 1 control; a forward flag marks a read that raced the write-back of
  // the previous sample to the same column (a frame start right after a sample in column 0).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_accept;
      s1_fwd_q   <= in_accept && s1_valid_q && (col0 == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q     <= col0;
      s1_sample_q  <= s_axis_tdata;
      s1_produce_q <= produce0;
      s1_last_q    <= last0;
    end
    if (wr_en) begin
      fwd_mid_q    <= mid1;
      fwd_sample_q <= s1_sample_q;
    end
  end

  assign top1 = s1_fwd_q ? fwd_mid_q    : rd_b;
  assign mid1 = s1_fwd_q ? fwd_sample_q : rd_a;

  // ---------------------------------------------------------------------------
  // Window: entries 0..2 hold column col-1, 3..5 column col-2 (top, mid, bottom).
  logic [SampleW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (wr_en) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top1;
      win_q[1] <= mid1;
      win_q[2] <= s1_sample_q;
    end
  end

  // Neighbor sums of the completed 3x3 neighborhood.
  logic [SumW-1:0] corner_sum1, edge_sum1;

  assign corner_sum1 = SumW'(win_q[3]) + SumW'(win_q[5]) + SumW'(top1) + SumW'(s1_sample_q);
  assign edge_sum1   = SumW'(win_q[0]) + SumW'(win_q[2]) + SumW'(win_q[4]) + SumW'(mid1);

  // ---------------------------------------------------------------------------
  // Stage 2: sums registered, weighted terms formed.
  logic               s2_valid_q, s2_last_q;
  logic [SumW-1:0]    corner_sum_q, edge_sum_q;
  logic [SampleW-1:0] center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_produce_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      corner_sum_q <= corner_sum1;
      edge_sum_q   <= edge_sum1;
      center_q     <= win_q[1];
      s2_last_q    <= s1_last_q;
    end
  end

  logic signed [ProdW-1:0] prod_c2, prod_e2, prod_m2;

  assign prod_c2 = $signed(w_corner_q) * $signed({1'b0, corner_sum_q});
  assign prod_e2 = $signed(w_edge_q)   * $signed({1'b0, edge_sum_q});
  assign prod_m2 = $signed(w_center_q) * $signed({{(SumW - SampleW + 1){1'b0}}, center_q});

  // ---------------------------------------------------------------------------
  // Stage 3: products registered, summed, rounded and saturated.
  logic                    s3_valid_q, s3_last_q;
  logic signed [ProdW-1:0] prod_c_q, prod_e_q, prod_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_c_q  <= prod_c2;
      prod_e_q  <= prod_e2;
      prod_m_q  <= prod_m2;
      s3_last_q <= s2_last_q;
    end
  end

  logic [AccW-1:0]                       acc3;
  logic [AccW-ss3x3_pkg::FracBits-1:0]   scaled3;
  logic [SampleW-1:0]                    result3;

  always_comb begin
    acc3 = AccW'(prod_c_q) + AccW'(prod_e_q) + AccW'(prod_m_q) + ss3x3_pkg::RoundHalf;
    scaled3 = acc3[AccW-1:ss3x3_pkg::FracBits];
    if (acc3[AccW-1]) begin
      result3 = '0;
    end else if (|scaled3[AccW-ss3x3_pkg::FracBits-1:SampleW]) begin
      result3 = '1;
    end else begin
      result3 = scaled3[SampleW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  logic [SampleW-1:0] out_data_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result3;
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/ss3x3_checker.sv */
module ss3x3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ss3x3_pkg::SampleW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // The output holds no result while or right after reset.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

  // A result that is not taken stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A waiting result stops new samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("sample request taken while output is blocked");

  // With the output free, the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

bind stencil_smooth_3x3_core ss3x3_checker u_ss3x3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/smooth_checker.sv */
// Watches the configuration, sample and result channels of the 3x3 smoothing core,
// predicts each filtered sample and compares it with what the core delivers.
module smooth_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration channel.
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [ss3x3_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ss3x3_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample stream into the core.
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [ss3x3_pkg::SampleW-1:0]    in_data_i,    // [15:0] sample
  input  logic                             in_user_i,    // [0] frame_start
  // Filtered stream out of the core.
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [ss3x3_pkg::SampleW-1:0]    out_data_i,   // [15:0] smoothed
  input  logic                             out_last_i,   // last_of_frame
  // End of stimulus: any filtered sample still awaited is an error.
  input  logic                             finish_i,
  output int                               outstanding_o,
  output int                               errors_o
);
  import ss3x3_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] smoothed;
    logic               frame_end;
  } pixel_t;

  // Mirror of the core's registers.
  logic [SizeW-1:0]          side_len;
  logic signed [WeightW-1:0] w_corner;
  logic signed [WeightW-1:0] w_orth;
  logic signed [WeightW-1:0] w_center;

  // Mirror of the line stores, the window and the position counters.
  logic [SampleW-1:0] row_prev  [MaxWidth];
  logic [SampleW-1:0] row_prev2 [MaxWidth];
  logic [SampleW-1:0] window    [6];
  int unsigned        col_pos;
  int unsigned        row_pos;

  pixel_t expected_px [$];
  pixel_t head_px;
  int     err_cnt = 0;
  bit     leftovers_checked;

  task automatic report_mismatch(input string what);
    $display("[%0t] smoothing mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Takes one sample into the mirrored state and queues the filtered value it completes.
  task automatic filter_sample(input logic [SampleW-1:0] smp, input logic frame_start);
    int unsigned        side;
    int unsigned        c;
    int unsigned        r;
    logic [SampleW-1:0] top_s;
    logic [SampleW-1:0] mid_s;
    longint             diag;
    longint             orth;
    longint             acc;
    longint             quo;
    pixel_t             px;
    if (side_len < 3) begin
      side = 3;
    end else if (side_len > MaxWidth) begin
      side = MaxWidth;
    end else begin
      side = side_len;
    end
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // A size shrunk mid-frame pins the counters to the last column and row.
    c = (col_pos >= side) ? side - 1 : col_pos;
    r = (row_pos >= side) ? side - 1 : row_pos;

    top_s        = row_prev2[c];
    mid_s        = row_prev[c];
    row_prev2[c] = mid_s;
    row_prev[c]  = smp;

    if (r >= 2 && c >= 2) begin
      diag = longint'(window[3]) + longint'(window[5]) + longint'(top_s) + longint'(smp);
      orth = longint'(window[0]) + longint'(window[2]) + longint'(window[4])
           + longint'(mid_s);
      acc  = longint'(w_corner) * diag + longint'(w_orth) * orth
           + longint'(w_center) * longint'(window[1]) + 64'sd16384;
      // Round to the sample format and clamp to the unsigned range.
      if (acc < 0) begin
        quo = 0;
      end else begin
        quo = acc >>> 15;
        if (quo > 65535) begin
          quo = 65535;
        end
      end
      px.smoothed  = quo[SampleW-1:0];
      px.frame_end = (r == side - 1) && (c == side - 1);
      expected_px.push_back(px);
    end

    window[3] = window[0];
    window[4] = window[1];
    window[5] = window[2];
    window[0] = top_s;
    window[1] = mid_s;
    window[2] = smp;

    if (c + 1 >= side) begin
      col_pos = 0;
      row_pos = (r + 1 >= side) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Follow every request on the three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_len = ResetImageSize;
      w_corner = ResetWeightCorner;
      w_orth   = ResetWeightEdge;
      w_center = ResetWeightCenter;
      for (int i = 0; i < MaxWidth; i++) begin
        row_prev[i]  = '0;
        row_prev2[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
        window[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      expected_px.delete();
      leftovers_checked = 1'b0;
      outstanding_o <= 0;
      errors_o      <= err_cnt;
    end else begin
      // Results first: none can stem from a sample taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data_i));
        end else begin
          head_px = expected_px.pop_front();
          if (out_data_i !== head_px.smoothed) begin
            report_mismatch($sformatf("smoothed %h, predicted %h", out_data_i,
                                      head_px.smoothed));
          end
          if (out_last_i !== head_px.frame_end) begin
            report_mismatch($sformatf("tlast %b, predicted %b", out_last_i,
                                      head_px.frame_end));
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_SIZE:    side_len = cfg_data_i[SizeW-1:0];
          CFG_WEIGHT_CORNER: w_corner = cfg_data_i;
          CFG_WEIGHT_EDGE:   w_orth   = cfg_data_i;
          CFG_WEIGHT_CENTER: w_center = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        filter_sample(in_data_i, in_user_i);
      end

      if (finish_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_px.size() != 0) begin
          report_mismatch($sformatf("%0d results never delivered", expected_px.size()));
        end
      end

      outstanding_o <= expected_px.size();
      errors_o      <= err_cnt;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Stimulus and verdict for the 3x3 smoothing core. Prediction and comparison live in
// smooth_checker, which sits beside the core and reports its error count here.
module testbench;
  import ss3x3_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 560;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SampleW-1:0]   s_axis_tdata;   // [15:0] sample
  logic                 s_axis_tuser;   // [0] frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [SampleW-1:0]   m_axis_tdata;   // [15:0] smoothed
  logic                 m_axis_tlast;   // last_of_frame

  logic                 run_done;
  int                   outstanding;
  int                   errors;
  int unsigned          src_idle_pct;
  int unsigned          snk_stall_pct;
  int unsigned          hold_req;
  int unsigned          idle_cycles = 0;
  int unsigned          frame_side;
  int unsigned          frame_pos;

  stencil_smooth_3x3_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  smooth_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .out_last_i    (m_axis_tlast),
    .finish_i      (run_done),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result sink: random stalls, plus a long hold-off whenever one is requested.
  initial begin : sink
    int unsigned holds_seen;
    int unsigned hold_left;
    holds_seen = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_seen != hold_req) begin
        holds_seen = hold_req;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: too long without any request on any channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one sample after a random gap and returns at the edge that takes it.
  task automatic push_sample(input logic [SampleW-1:0] smp, input logic frame_start);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [SizeW-1:0] size, input logic [WeightW-1:0] wc,
                              input logic [WeightW-1:0] we, input logic [WeightW-1:0] wm);
    write_reg(CFG_IMAGE_SIZE, CfgDataW'(size));
    write_reg(CFG_WEIGHT_CORNER, wc);
    write_reg(CFG_WEIGHT_EDGE, we);
    write_reg(CFG_WEIGHT_CENTER, wm);
    cfg_valid <= 1'b0;
    if (size < 3) begin
      frame_side = 3;
    end else if (size > MaxWidth) begin
      frame_side = MaxWidth;
    end else begin
      frame_side = size;
    end
  endtask

  // Waits for every predicted result, then lets the pipeline empty of border samples.
  task automatic wait_idle();
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      default: return WeightW'($urandom);
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(9))
      0:       return SizeW'($urandom_range(2));
      1:       return SizeW'($urandom_range(24, 11));
      default: return SizeW'($urandom_range(10, 3));
    endcase
  endfunction

  // Streams frames in raster order: mostly whole frames opened by frame_start, some
  // that rely on the counters wrapping, and a few cut short by an early frame_start.
  task automatic stream_items(input int unsigned count, input bit fresh_frame);
    logic [SampleW-1:0] smp;
    logic               fs;
    for (int unsigned k = 0; k < count; k++) begin
      fs = 1'b0;
      if (k == 0 && fresh_frame) begin
        fs        = 1'b1;
        frame_pos = 0;
      end else if (frame_pos >= frame_side * frame_side) begin
        fs        = ($urandom_range(5) != 0);
        frame_pos = 0;
      end else if ($urandom_range(39) == 0) begin
        fs        = 1'b1;
        frame_pos = 0;
      end
      smp = pick_sample();
      push_sample(smp, fs);
      frame_pos++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned budget;
    int unsigned chunk;
    rst_ni        <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_IMAGE_SIZE;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    run_done      <= 1'b0;
    src_idle_pct  <= 0;
    snk_stall_pct <= 0;
    hold_req      <= 0;
    frame_side    = MaxWidth;
    frame_pos     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, full-scale samples and largest weights: saturates high.
    program_regs(11'd3, 16'h7fff, 16'h7fff, 16'h7fff);
    for (int i = 0; i < 9; i++) begin
      push_sample(16'hffff, i == 0);
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // Size below three, most negative weights, next frame entered by wrap alone.
    program_regs(11'd0, 16'h8000, 16'h8000, 16'h8000);
    for (int i = 0; i < 9; i++) begin
      push_sample((i % 2 == 0) ? 16'hffff : 16'h0000, 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // A frame abandoned after three samples by a new frame_start.
    program_regs(11'd2, 16'h0001, 16'h4000, 16'h0000);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h7ffe, 1'b0);
    push_sample(16'h1234, 1'b1);
    for (int i = 0; i < 8; i++) begin
      push_sample(pick_sample(), 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // Oversized setting acts as the full line width: a long first row does not wrap.
    program_regs(11'd2047, pick_weight(), pick_weight(), pick_weight());
    stream_items(300, 1'b1);
    wait_idle();

    // Shrink in the middle of the first row: the counters pin and then wrap. The two
    // rows that follow leave both line stores written across the widest random frame.
    program_regs(11'd24, pick_weight(), pick_weight(), pick_weight());
    for (int i = 0; i < 60; i++) begin
      push_sample(pick_sample(), 1'b0);
    end
    s_axis_tvalid <= 1'b0;

    // Random frames under each idling pattern.
    for (int unsigned mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 0;
        end
        1: begin
          src_idle_pct  <= 88;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 88;
        end
        default: begin
          src_idle_pct  <= 34;
          snk_stall_pct <= 34;
        end
      endcase
      budget = 0;
      while (budget < RandomItems / 4) begin
        wait_idle();
        program_regs(pick_size(), pick_weight(), pick_weight(), pick_weight());
        if (mode == 0 && budget == 0) begin
          // Long sink hold-off while samples keep coming, so the core backs up.
          hold_req <= hold_req + 1;
          chunk = 150;
        end else begin
          chunk = $urandom_range(110, 20);
        end
        stream_items(chunk, $urandom_range(3) != 0);
        budget += chunk;
      end
    end

    wait_idle();
    run_done <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* stencil_smooth_3x3_core.f */
rtl/core/ss3x3_pkg.sv
rtl/core/ss3x3_ram.sv
rtl/core/stencil_smooth_3x3_core.sv
rtl/core/ss3x3_checker.sv
tb/sv/smooth_checker.sv
tb/sv/testbench.sv
